// ===== src/u8t_pkg.sv =====
// ----------------------------------------------------------------------------
// u8t_pkg: shared types and constants for the 8N1 UART transceiver
// Holds field widths, the register map, the reset divisor and the
// receiver and transmitter state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package u8t_pkg;

  // Field and counter widths.
  localparam int BYTE_W   = 8;
  localparam int TPB_W    = 16;
  localparam int RX_CNT_W = 17;
  localparam int IDX_W    = 4;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 2;

  // Divisor reset value and floor.
  localparam logic [TPB_W-1:0] TPB_RESET = 16'd104;
  localparam logic [TPB_W-1:0] TPB_MIN   = 16'd2;

  // Register map, as word indexes.
  localparam int REG_TICKS_PER_BIT = 0;

  // Receiver phases.
  typedef enum logic [1:0] {
    RX_WAIT_IDLE  = 2'd0,
    RX_WAIT_START = 2'd1,
    RX_DATA       = 2'd2,
    RX_STOP       = 2'd3
  } rx_phase_t;

  // Transmitter phases.
  typedef enum logic [2:0] {
    TX_IDLE  = 3'd0,
    TX_START = 3'd1,
    TX_DATA  = 3'd2,
    TX_STOP  = 3'd3,
    TX_GUARD = 3'd4
  } tx_phase_t;

endpackage

`default_nettype wire

// ===== src/uart_8n1_transceiver.sv =====
// ----------------------------------------------------------------------------
// uart_8n1_transceiver: tick-paced 8N1 UART receiver and transmitter
// Each input beat is one timebase tick carrying the sampled receive line
// and an optional send request; each tick yields one result beat.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one tick per beat:
//   rx_line, send_request and send_byte. The output channel
//   (out_valid/out_ready) returns one beat per tick: tx_line, tx_busy,
//   rx_valid and rx_byte, showing the state after that tick.
//   An accepted tick is registered in the result register and shows on
//   the output in the cycle after it is taken. Throughput is one tick per
//   cycle; the receiver and transmitter counters are updated by a single
//   pass of logic on each accepted beat, and the result register is refilled
//   in the same cycle that its beat is taken.
//   When the output side stalls, the result register holds its beat and
//   in_ready drops, so no tick is lost and no timer advances.
//   Reset clears both state machines, sets the line idle high, loads the
//   divisor with 104 and empties the result register.
//   The divisor (ticks_per_bit, byte address 0) is written over the APB
//   port; values below 2 act as 2. pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_8n1_transceiver
  import u8t_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Configuration port.
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready,
  // Tick input channel.
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                rx_line,
  input  wire logic                send_request,
  input  wire logic [BYTE_W-1:0]   send_byte,
  // Result channel.
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     tx_line,
  output logic                     tx_busy,
  output logic                     rx_valid,
  output logic [BYTE_W-1:0]        rx_byte
);

  localparam logic [IDX_W-1:0]  WORD_BITS = IDX_W'(DATA_BITS);
  localparam logic [BYTE_W-1:0] WORD_MASK = BYTE_W'((1 << DATA_BITS) - 1);

  // Configuration register.
  logic [TPB_W-1:0] ticks_per_bit;
  logic             cfg_write;

  // Receiver state.
  rx_phase_t             rx_phase, rx_phase_next;
  logic [RX_CNT_W-1:0]   rx_tick_count, rx_tick_count_next, rx_count_dec;
  logic [IDX_W-1:0]      rx_bit_index, rx_bit_index_next, rx_index_inc;
  logic [BYTE_W-1:0]     rx_shift, rx_shift_next;
  logic [BYTE_W-1:0]     rx_last, rx_last_next;
  logic                  rx_done;
  logic                  rx_expire;

  // Transmitter state.
  tx_phase_t             tx_phase, tx_phase_next;
  logic [TPB_W-1:0]      tx_tick_count, tx_tick_count_next, tx_count_dec;
  logic [IDX_W-1:0]      tx_bit_index, tx_bit_index_next, tx_index_inc;
  logic [BYTE_W-1:0]     tx_shift, tx_shift_next;
  logic                  tx_level, tx_level_next;
  logic                  tx_expire;

  logic [TPB_W-1:0]      period;
  logic                  in_beat;

  // APB access: single register, always ready.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = APB_DW'(ticks_per_bit);

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_bit <= TPB_RESET;
    end else if (cfg_write && (32'(paddr >> 2) == REG_TICKS_PER_BIT)) begin
      ticks_per_bit <= pwdata[TPB_W-1:0];
    end
  end

  // Bit period with the divisor floor applied.
  assign period = (ticks_per_bit < TPB_MIN) ? TPB_MIN : ticks_per_bit;

  // A tick is taken whenever the result register is free or being emptied.
  assign in_ready = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;

  // Receiver timer decrement and expiry.
  assign rx_count_dec = rx_tick_count - RX_CNT_W'(1);
  assign rx_expire    = (rx_count_dec == '0);
  assign rx_index_inc = rx_bit_index + IDX_W'(1);

  // Receiver next phase.
  always_comb begin
    rx_phase_next = rx_phase;
    unique case (rx_phase)
      RX_WAIT_IDLE: begin
        if (rx_line) rx_phase_next = RX_WAIT_START;
      end
      RX_WAIT_START: begin
        if (!rx_line) rx_phase_next = RX_DATA;
      end
      RX_DATA: begin
        if (rx_expire && (rx_index_inc >= WORD_BITS)) rx_phase_next = RX_STOP;
      end
      RX_STOP: begin
        if (rx_expire) rx_phase_next = RX_WAIT_IDLE;
      end
    endcase
  end

  // Receiver timer, sampling and byte capture.
  always_comb begin
    rx_tick_count_next = rx_tick_count;
    rx_bit_index_next  = rx_bit_index;
    rx_shift_next      = rx_shift;
    rx_last_next       = rx_last;
    rx_done            = 1'b0;
    unique case (rx_phase)
      RX_WAIT_IDLE: begin
      end
      RX_WAIT_START: begin
        // Start edge: first sample lands one and a half bits later.
        if (!rx_line) begin
          rx_tick_count_next = RX_CNT_W'(period) + RX_CNT_W'(period >> 1);
          rx_bit_index_next  = '0;
        end
      end
      RX_DATA: begin
        rx_tick_count_next = rx_count_dec;
        if (rx_expire) begin
          rx_shift_next[rx_bit_index[2:0]] = rx_line;
          rx_bit_index_next  = rx_index_inc;
          rx_tick_count_next = RX_CNT_W'(period);
        end
      end
      RX_STOP: begin
        rx_tick_count_next = rx_count_dec;
        if (rx_expire) begin
          rx_last_next = rx_shift & WORD_MASK;
          rx_done      = 1'b1;
        end
      end
    endcase
  end

  // Transmitter timer decrement and expiry.
  assign tx_count_dec = tx_tick_count - TPB_W'(1);
  assign tx_expire    = (tx_count_dec == '0);
  assign tx_index_inc = tx_bit_index + IDX_W'(1);

  // Transmitter next phase.
  always_comb begin
    tx_phase_next = tx_phase;
    unique case (tx_phase)
      TX_IDLE: begin
        if (send_request) tx_phase_next = TX_START;
      end
      TX_START: begin
        if (tx_expire) tx_phase_next = TX_DATA;
      end
      TX_DATA: begin
        if (tx_expire && (tx_index_inc >= WORD_BITS)) tx_phase_next = TX_STOP;
      end
      TX_STOP: begin
        if (tx_expire) tx_phase_next = TX_GUARD;
      end
      TX_GUARD: begin
        if (tx_expire) tx_phase_next = TX_IDLE;
      end
      default: begin
        tx_phase_next = TX_IDLE;
      end
    endcase
  end

  // Transmitter timer, shift data and line level.
  always_comb begin
    tx_tick_count_next = tx_tick_count;
    tx_bit_index_next  = tx_bit_index;
    tx_shift_next      = tx_shift;
    tx_level_next      = tx_level;
    unique case (tx_phase)
      TX_IDLE: begin
        // Requests are only honored here; a busy transmitter drops them.
        if (send_request) begin
          tx_shift_next      = send_byte;
          tx_bit_index_next  = '0;
          tx_tick_count_next = period;
          tx_level_next      = 1'b0;
        end
      end
      TX_START: begin
        tx_tick_count_next = tx_expire ? period : tx_count_dec;
        if (tx_expire) begin
          tx_bit_index_next = '0;
          tx_level_next     = tx_shift[0];
        end
      end
      TX_DATA: begin
        tx_tick_count_next = tx_expire ? period : tx_count_dec;
        if (tx_expire) begin
          tx_bit_index_next = tx_index_inc;
          tx_level_next     = (tx_index_inc < WORD_BITS) ?
                              tx_shift[tx_index_inc[2:0]] : 1'b1;
        end
      end
      TX_STOP: begin
        tx_tick_count_next = tx_expire ? period : tx_count_dec;
        if (tx_expire) tx_level_next = 1'b1;
      end
      TX_GUARD: begin
        tx_tick_count_next = tx_expire ? '0 : tx_count_dec;
        if (tx_expire) tx_level_next = 1'b1;
      end
      default: begin
        tx_level_next = 1'b1;
      end
    endcase
  end

  // State update on each accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase      <= RX_WAIT_IDLE;
      rx_tick_count <= '0;
      rx_bit_index  <= '0;
      rx_shift      <= '0;
      rx_last       <= '0;
      tx_phase      <= TX_IDLE;
      tx_tick_count <= '0;
      tx_bit_index  <= '0;
      tx_shift      <= '0;
      tx_level      <= 1'b1;
    end else if (in_beat) begin
      rx_phase      <= rx_phase_next;
      rx_tick_count <= rx_tick_count_next;
      rx_bit_index  <= rx_bit_index_next;
      rx_shift      <= rx_shift_next;
      rx_last       <= rx_last_next;
      tx_phase      <= tx_phase_next;
      tx_tick_count <= tx_tick_count_next;
      tx_bit_index  <= tx_bit_index_next;
      tx_shift      <= tx_shift_next;
      tx_level      <= tx_level_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      tx_line  <= tx_level_next;
      tx_busy  <= (tx_phase_next != TX_IDLE);
      rx_valid <= rx_done;
      rx_byte  <= rx_last_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/u8t_checker.sv =====
// ----------------------------------------------------------------------------
// u8t_checker: port-level checks for the 8N1 UART transceiver
// Watches the result channel and the configuration port over time.
// ----------------------------------------------------------------------------
`default_nettype none

module u8t_checker
  import u8t_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              pready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              tx_line,
  input wire logic              tx_busy,
  input wire logic              rx_valid,
  input wire logic [BYTE_W-1:0] rx_byte
);

  logic              out_beat;
  logic              seen;
  logic              last_rx_valid;
  logic [BYTE_W-1:0] last_rx_byte;

  assign out_beat = out_valid && out_ready;

  // Remember the previous result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen          <= 1'b0;
      last_rx_valid <= 1'b0;
    end else if (out_beat) begin
      seen          <= 1'b1;
      last_rx_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) last_rx_byte <= rx_byte;
  end

  // A stalled result beat keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rx_byte) && $stable(tx_line))
    else $error("result beat changed while stalled");

  // An idle transmitter holds the line high.
  a_idle_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_busy |-> tx_line)
    else $error("tx_line low while transmitter idle");

  // The received byte only changes along with a receive pulse.
  a_byte_held: assert property (@(posedge clk) disable iff (rst)
    out_beat && seen && !rx_valid |-> rx_byte == last_rx_byte)
    else $error("rx_byte changed without rx_valid");

  // A receive pulse never lasts two consecutive ticks.
  a_pulse_single: assert property (@(posedge clk) disable iff (rst)
    out_beat && seen && last_rx_valid |-> !rx_valid)
    else $error("rx_valid high on consecutive ticks");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind uart_8n1_transceiver u8t_checker u_u8t_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .tx_line   (tx_line),
  .tx_busy   (tx_busy),
  .rx_valid  (rx_valid),
  .rx_byte   (rx_byte)
);

`default_nettype wire

// ===== sim/uart_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_frame_checker: tick-by-tick predictor and result comparator
// Watches the divisor writes and the tick channel, runs its own copy of the
// receiver and transmitter, and compares every result beat, field by field,
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module uart_frame_checker
  import u8t_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              rx_line,
  input  logic              send_request,
  input  logic [BYTE_W-1:0] send_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              tx_line,
  input  logic              tx_busy,
  input  logic              rx_valid,
  input  logic [BYTE_W-1:0] rx_byte,
  output int                fail_count,
  output int                pending,
  output int                ticks_seen,
  output int                bytes_seen,
  output int                frames_sent
);

  localparam logic [IDX_W-1:0]  WORD_BITS    = IDX_W'(DATA_BITS);
  localparam logic [BYTE_W-1:0] WORD_MASK    = BYTE_W'((1 << DATA_BITS) - 1);
  localparam logic [APB_AW-1:0] DIVISOR_ADDR = APB_AW'(REG_TICKS_PER_BIT * 4);

  // One result beat as the line would show it after a tick.
  typedef struct packed {
    logic              tx_line;
    logic              tx_busy;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
  } line_view_t;

  // Predicted divisor and transceiver state.
  logic [TPB_W-1:0]    divisor;
  rx_phase_t           rx_state;
  logic [RX_CNT_W-1:0] rx_timer;
  logic [IDX_W-1:0]    rx_bits;
  logic [BYTE_W-1:0]   rx_word;
  logic [BYTE_W-1:0]   rx_held;
  tx_phase_t           tx_state;
  logic [TPB_W-1:0]    tx_timer;
  logic [IDX_W-1:0]    tx_bits;
  logic [BYTE_W-1:0]   tx_word;
  logic                tx_level;

  line_view_t expected_views[$];
  int         fails;
  int         ticks;
  int         received;
  int         started;

  // Bit period in ticks, with the floor on tiny divisors.
  function automatic logic [TPB_W-1:0] floored_period();
    return (divisor < TPB_MIN) ? TPB_MIN : divisor;
  endfunction

  function automatic void compare_field(string name, logic [BYTE_W-1:0] want,
                                        logic [BYTE_W-1:0] seen);
    if (want !== seen) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, seen);
      fails++;
    end
  endfunction

  // Advance receiver and transmitter by one tick and return the line view.
  task automatic step_uart(input logic line, input logic req,
                           input logic [BYTE_W-1:0] data, output line_view_t view);
    logic [TPB_W-1:0] period;
    logic             got;
    period = floored_period();
    got    = 1'b0;

    // Receiver: idle wait, start detect, mid-bit sampling, stop centre.
    case (rx_state)
      RX_WAIT_IDLE: begin
        if (line) rx_state = RX_WAIT_START;
      end
      RX_WAIT_START: begin
        if (!line) begin
          rx_timer = RX_CNT_W'(period) + RX_CNT_W'(period >> 1);
          rx_bits  = '0;
          rx_state = RX_DATA;
        end
      end
      RX_DATA: begin
        rx_timer = rx_timer - RX_CNT_W'(1);
        if (rx_timer == '0) begin
          rx_word[rx_bits[2:0]] = line;
          rx_bits  = rx_bits + IDX_W'(1);
          rx_timer = RX_CNT_W'(period);
          if (rx_bits >= WORD_BITS) rx_state = RX_STOP;
        end
      end
      default: begin
        rx_timer = rx_timer - RX_CNT_W'(1);
        if (rx_timer == '0) begin
          rx_held  = rx_word & WORD_MASK;
          got      = 1'b1;
          rx_state = RX_WAIT_IDLE;
        end
      end
    endcase

    // Transmitter: a request is taken only when idle at the start of the tick.
    if (tx_state == TX_IDLE) begin
      if (req) begin
        tx_word  = data;
        tx_bits  = '0;
        tx_timer = period;
        tx_level = 1'b0;
        tx_state = TX_START;
        started++;
      end
    end else begin
      tx_timer = tx_timer - TPB_W'(1);
      if (tx_timer == '0) begin
        tx_timer = period;
        case (tx_state)
          TX_START: begin
            tx_bits  = '0;
            tx_level = tx_word[0];
            tx_state = TX_DATA;
          end
          TX_DATA: begin
            tx_bits = tx_bits + IDX_W'(1);
            if (tx_bits < WORD_BITS) begin
              tx_level = tx_word[tx_bits[2:0]];
            end else begin
              tx_level = 1'b1;
              tx_state = TX_STOP;
            end
          end
          TX_STOP: begin
            tx_level = 1'b1;
            tx_state = TX_GUARD;
          end
          default: begin
            tx_level = 1'b1;
            tx_timer = '0;
            tx_state = TX_IDLE;
          end
        endcase
      end
    end

    view.tx_line  = tx_level;
    view.tx_busy  = (tx_state != TX_IDLE);
    view.rx_valid = got;
    view.rx_byte  = rx_held;
  endtask

  // Follow the channels on every edge; the counters go out registered.
  always @(posedge clk) begin
    line_view_t predicted;
    line_view_t oldest;
    if (rst) begin
      divisor  = TPB_RESET;
      rx_state = RX_WAIT_IDLE;
      rx_timer = '0;
      rx_bits  = '0;
      rx_word  = '0;
      rx_held  = '0;
      tx_state = TX_IDLE;
      tx_timer = '0;
      tx_bits  = '0;
      tx_word  = '0;
      tx_level = 1'b1;
      expected_views.delete();
      fails    = 0;
      ticks    = 0;
      received = 0;
      started  = 0;
    end else begin
      // Divisor write on the access cycle.
      if (psel && penable && pwrite && pready && paddr == DIVISOR_ADDR) begin
        divisor = pwdata[TPB_W-1:0];
      end

      // Each accepted tick beat yields exactly one predicted result.
      if (in_valid && in_ready) begin
        step_uart(rx_line, send_request, send_byte, predicted);
        expected_views.push_back(predicted);
        ticks++;
      end

      // Result beats are matched in order.
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          $error("result beat arrived with no tick outstanding");
          fails++;
        end else begin
          oldest = expected_views.pop_front();
          compare_field("tx_line", BYTE_W'(oldest.tx_line), BYTE_W'(tx_line));
          compare_field("tx_busy", BYTE_W'(oldest.tx_busy), BYTE_W'(tx_busy));
          compare_field("rx_valid", BYTE_W'(oldest.rx_valid), BYTE_W'(rx_valid));
          compare_field("rx_byte", oldest.rx_byte, rx_byte);
          if (rx_valid) received++;
        end
      end
    end
    fail_count  <= fails;
    pending     <= expected_views.size();
    ticks_seen  <= ticks;
    bytes_seen  <= received;
    frames_sent <= started;
  end

endmodule

// ===== sim/uart_8n1_transceiver_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_8n1_transceiver_test: stimulus and verdict for the 8N1 UART
// Feeds timebase ticks carrying receive frames, broken frames and line noise
// together with random send requests, across a range of divisor settings
// from tiny to full scale, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------

module uart_8n1_transceiver_test;
  import u8t_pkg::*;

  localparam int DATA_BITS   = 8;
  localparam int PHASES      = 10;
  localparam int PHASE_TICKS = 145;
  localparam int CYCLE_LIMIT = 200000;

  // Kinds of traffic put on the receive line.
  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_STOP,
    FRAME_CUT,
    LINE_NOISE
  } rx_traffic_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              rx_line = 1'b1;
  logic              send_request = 1'b0;
  logic [BYTE_W-1:0] send_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              tx_line;
  logic              tx_busy;
  logic              rx_valid;
  logic [BYTE_W-1:0] rx_byte;

  int fail_count;
  int pending;
  int ticks_seen;
  int bytes_seen;
  int frames_sent;

  // Stimulus-side copy of the divisor, used to shape receive frames.
  logic [TPB_W-1:0] divisor = TPB_RESET;
  int               settings_used = 1;
  int               burst_left = 0;
  logic             line_plan[$];
  logic [TPB_W-1:0] phase_div[PHASES] = '{2, 3, 1, 5, 4, 0, 7, 2, 6, 3};

  int   stall_left = 0;
  int   stall_mode = 0;
  int   cycle_count = 0;

  always #5 clk = ~clk;

  uart_8n1_transceiver #(
    .DATA_BITS(DATA_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_line(rx_line),
    .send_request(send_request),
    .send_byte(send_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tx_line(tx_line),
    .tx_busy(tx_busy),
    .rx_valid(rx_valid),
    .rx_byte(rx_byte)
  );

  uart_frame_checker #(
    .DATA_BITS(DATA_BITS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .pready(pready),
    .paddr(paddr),
    .pwdata(pwdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_line(rx_line),
    .send_request(send_request),
    .send_byte(send_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tx_line(tx_line),
    .tx_busy(tx_busy),
    .rx_valid(rx_valid),
    .rx_byte(rx_byte),
    .fail_count(fail_count),
    .pending(pending),
    .ticks_seen(ticks_seen),
    .bytes_seen(bytes_seen),
    .frames_sent(frames_sent)
  );

  // Result side: runs of full speed, random stalls and a slow fixed pattern.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 1) == 0);
      default: out_ready <= (stall_left % 4 == 0);
    endcase
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Present one tick beat and hold it until taken; bursts end in random gaps.
  task automatic send_tick(input logic line, input logic req,
                           input logic [BYTE_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    rx_line      <= line;
    send_request <= req;
    send_byte    <= data;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Setup and access cycles of a divisor write, taken while the channels idle.
  task automatic write_divisor(input logic [TPB_W-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(REG_TICKS_PER_BIT * 4);
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    divisor = value;
    settings_used++;
  endtask

  // Append one piece of receive-line traffic, timed at the current divisor.
  task automatic plan_rx(input rx_traffic_t kind, input logic [BYTE_W-1:0] data);
    int   span;
    int   idle;
    int   keep;
    logic frame[$];
    span = (divisor < TPB_MIN) ? TPB_MIN : divisor;
    idle = $urandom_range(1, 2 * span);
    repeat (idle) frame.push_back(1'b1);
    if (kind == LINE_NOISE) begin
      repeat ($urandom_range(1, 3 * span)) frame.push_back(1'($urandom));
    end else begin
      repeat (span) frame.push_back(1'b0);
      for (int i = 0; i < BYTE_W; i++) begin
        repeat (span) frame.push_back(data[i]);
      end
      repeat (span) frame.push_back(kind != FRAME_BAD_STOP);
      // A cut frame stops somewhere after its start bit began.
      if (kind == FRAME_CUT) begin
        keep = $urandom_range(idle + 1, frame.size() - span - 1);
        while (frame.size() > keep) void'(frame.pop_back());
      end
    end
    line_plan = {line_plan, frame};
  endtask

  // One random tick: receive traffic is mostly clean frames, send requests
  // come at a per-phase rate.
  task automatic random_tick(input int req_odds);
    int          pick;
    rx_traffic_t kind;
    logic        level;
    if (line_plan.size() == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)       kind = FRAME_GOOD;
      else if (pick == 7) kind = FRAME_BAD_STOP;
      else if (pick == 8) kind = FRAME_CUT;
      else                kind = LINE_NOISE;
      plan_rx(kind, 8'($urandom));
    end
    level = line_plan.pop_front();
    send_tick(level, $urandom_range(0, req_odds) == 0, 8'($urandom));
  endtask

  initial begin
    logic             level;
    logic [TPB_W-1:0] next_div;
    int               req_odds;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // At the reset divisor: a low line before idle is ignored, then a start
    // bit and a send request, followed by a request while busy.
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b1, 1'b0, 8'h00);
    send_tick(1'b1, 1'b1, 8'hA5);
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b1, 8'h5A);
    send_tick(1'b1, 1'b1, 8'hFF);

    // Zero divisor while both timers run long counts: the running counts
    // finish, and later bits use the floor of two ticks.
    write_divisor(16'd0);
    repeat (200) send_tick(1'b1, 1'b0, 8'h00);

    // All-zero and all-one frames both ways, with the request held high so
    // that the tick at which the guard ends sees a refused request.
    plan_rx(FRAME_GOOD, 8'h00);
    plan_rx(FRAME_GOOD, 8'hFF);
    while (line_plan.size() > 0) begin
      level = line_plan.pop_front();
      send_tick(level, 1'b1, (line_plan.size() > 24) ? 8'h00 : 8'hFF);
    end
    write_divisor(16'd1);

    // Random phases, mostly at small divisors so that many frames complete.
    for (int p = 0; p < PHASES; p++) begin
      next_div = (p % 3 == 2) ? 16'($urandom_range(2, 9)) : phase_div[p];
      req_odds = $urandom_range(0, 12);
      write_divisor(next_div);
      repeat (PHASE_TICKS) random_tick(req_odds);
    end

    // Full-scale divisor: start both directions and take a few ticks.
    write_divisor(16'hFFFF);
    send_tick(1'b1, 1'b0, 8'h00);
    send_tick(1'b0, 1'b1, 8'($urandom));
    repeat (30) send_tick(1'($urandom), 1'($urandom), 8'($urandom));

    drain();
    repeat (4) @(posedge clk);
    $display("Checked %0d ticks over %0d divisor settings, from tiny to full scale.",
             ticks_seen, settings_used);
    $display("Receiver delivered %0d bytes; transmitter started %0d frames.",
             bytes_seen, frames_sent);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
